// ----- rtl/core/shss_pkg.sv -----
// shared types and constants of the halving scatter schedule block
package shss_pkg;

  localparam int RANK_W     = 7;
  localparam int IDX_W      = 6;
  localparam int SLICE_W    = 40;
  localparam int BASE_W     = 48;
  localparam int STEP_W     = 3;
  localparam int REP_W      = 16;
  localparam int OFF_W      = 64;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int MAX_RANKS    = 64;
  localparam int RESULT_LIMIT = 32;

  localparam int MOD_CNT_W = 3;

  typedef enum logic [1:0] {
    ROLE_IDLE = 2'd0,
    ROLE_SEND = 2'd1,
    ROLE_RECV = 2'd2
  } role_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK_COUNT   = 3'd0,
    CFG_MY_INDEX     = 3'd1,
    CFG_ROOT_INDEX   = 3'd2,
    CFG_SLICE_SIZE   = 3'd3,
    CFG_SCRATCH_BASE = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PLAN,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic mul_lo;
    logic mul_hi;
    logic plan;
    logic prep;
    logic emit;
  } shss_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_slice;
  } shss_sts_t;

endpackage

// ----- rtl/core/shss_in_if.sv -----
// step request channel
interface shss_in_if import shss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step;
  logic [REP_W-1:0]  repeat_req;

  modport source (output valid, step, repeat_req, input ready);
  modport sink   (input valid, step, repeat_req, output ready);
endinterface

// ----- rtl/core/shss_out_if.sv -----
// transfer plan result channel
interface shss_out_if import shss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        role;
  logic [IDX_W-1:0]  peer_index;
  logic [IDX_W-1:0]  slice_index;
  logic [OFF_W-1:0]  byte_offset;
  logic [CNT_W-1:0]  slice_count;
  logic              last;

  modport source (output valid, role, peer_index, slice_index, byte_offset, slice_count, last,
                  input ready);
  modport sink   (input valid, role, peer_index, slice_index, byte_offset, slice_count, last,
                  output ready);
endinterface

// ----- rtl/core/shss_ctrl.sv -----
// sequencing state machine for the halving scatter schedule
module shss_ctrl import shss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  shss_sts_t sts,
  output shss_cmd_t cmd
);

  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(IDX_W - 1);

  state_t                 state_r, state_nxt;
  logic [MOD_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        // one remainder bit per cycle, the offset product rides along
        cmd.mod_step = 1'b1;
        cmd.mul_lo   = (cnt_r == MOD_CNT_W'(0));
        cmd.mul_hi   = (cnt_r == MOD_CNT_W'(1));
        if (cnt_r == MOD_LAST) begin
          state_nxt = ST_PLAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_slice) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/shss_dp.sv -----
// datapath: config registers, modulo unit, role planning and slice walk
module shss_dp import shss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  shss_cmd_t             cmd,
  output shss_sts_t             sts,
  input  logic [STEP_W-1:0]     in_step,
  input  logic [REP_W-1:0]      in_repeat_req,
  input  logic                  out_ready,
  output logic                  out_valid,
  output role_t                 out_role,
  output logic [IDX_W-1:0]      out_peer_index,
  output logic [IDX_W-1:0]      out_slice_index,
  output logic [OFF_W-1:0]      out_byte_offset,
  output logic [CNT_W-1:0]      out_slice_count,
  output logic                  out_last
);

  localparam int REPN_W = REP_W + RANK_W;
  localparam int HALF_W = SLICE_W / 2;
  localparam int PP_W   = REPN_W + HALF_W;
  localparam int PROD_W = IDX_W + SLICE_W;
  localparam int W8     = RANK_W + 1;
  localparam int W9     = RANK_W + 2;

  function automatic logic [STEP_W-1:0] steps_for(input logic [RANK_W-1:0] n);
    logic [STEP_W-1:0] s;
    s = '0;
    for (int i = 0; i < RANK_W; i++) begin
      if ((W8'(1) << i) < W8'(n)) s = s + 1'b1;
    end
    return s;
  endfunction

  // configuration
  logic [RANK_W-1:0]  rank_count_r;
  logic [IDX_W-1:0]   my_index_r;
  logic [IDX_W-1:0]   root_index_r;
  logic [SLICE_W-1:0] slice_size_r;
  logic [BASE_W-1:0]  scratch_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_count_r   <= RANK_W'(2);
      my_index_r     <= '0;
      root_index_r   <= '0;
      slice_size_r   <= '0;
      scratch_base_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANK_COUNT:   rank_count_r   <= cfg_wdata[RANK_W-1:0];
        CFG_MY_INDEX:     my_index_r     <= cfg_wdata[IDX_W-1:0];
        CFG_ROOT_INDEX:   root_index_r   <= cfg_wdata[IDX_W-1:0];
        CFG_SLICE_SIZE:   slice_size_r   <= cfg_wdata[SLICE_W-1:0];
        CFG_SCRATCH_BASE: scratch_base_r <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // per-item working registers
  logic [STEP_W-1:0]  step_r;
  logic [REPN_W-1:0]  rep_n_r;
  logic [IDX_W-1:0]   dvd_me_r, dvd_root_r;
  logic [IDX_W-1:0]   rem_me_r, rem_root_r;
  logic [OFF_W-1:0]   rbo_r, base_r;
  role_t              role_r;
  logic [IDX_W-1:0]   peer_r, idx_r;
  logic [RANK_W-1:0]  dsm_r;
  logic [CNT_W-1:0]   nsl_r, left_r;
  logic [PROD_W-1:0]  prod_r;

  logic [RANK_W-1:0]  n;
  assign n = rank_count_r;

  // restoring remainder, one dividend bit per cycle
  logic [RANK_W-1:0] me_t, root_t;
  logic [IDX_W-1:0]  me_rem_nxt, root_rem_nxt;
  always_comb begin
    me_t         = {rem_me_r, dvd_me_r[IDX_W-1]};
    root_t       = {rem_root_r, dvd_root_r[IDX_W-1]};
    me_rem_nxt   = (me_t >= n) ? IDX_W'(me_t - n) : IDX_W'(me_t);
    root_rem_nxt = (root_t >= n) ? IDX_W'(root_t - n) : IDX_W'(root_t);
  end

  // shared repeat offset multiplier, low half then high half of slice_size
  logic [HALF_W-1:0] half_sel;
  logic [PP_W-1:0]   pp;
  assign half_sel = cmd.mul_hi ? slice_size_r[SLICE_W-1:HALF_W] : slice_size_r[HALF_W-1:0];
  assign pp       = PP_W'(rep_n_r) * PP_W'(half_sel);

  // role planning
  logic              n_ok, step_ok, pow2, last_step, send, recv;
  logic [STEP_W-1:0] nsteps;
  logic [W8-1:0]     droot_t, dpair, nact;
  logic [RANK_W-1:0] droot;
  logic [W9-1:0]     dslice, nsl_raw, psend_t, precv_t;
  logic [IDX_W-1:0]  peer_send, peer_recv;
  logic [CNT_W-1:0]  nsl;
  logic [RANK_W-1:0] dsm;
  always_comb begin
    n_ok      = (n >= RANK_W'(2)) && (n <= RANK_W'(MAX_RANKS));
    nsteps    = steps_for(n);
    step_ok   = (step_r < nsteps);
    droot_t   = W8'(rem_root_r) + W8'(n) - W8'(rem_me_r);
    droot     = (droot_t >= W8'(n)) ? RANK_W'(droot_t - W8'(n)) : RANK_W'(droot_t);
    dpair     = W8'(1) << step_r;
    dslice    = W9'(1) << (W9'(step_r) + W9'(1));
    nsl_raw   = (W9'(n) - W9'(1) + W9'(dpair)) >> (W9'(step_r) + W9'(1));
    nsl       = (nsl_raw > W9'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT) : CNT_W'(nsl_raw);
    pow2      = ((n & (n - RANK_W'(1))) == '0);
    last_step = (step_r == nsteps - STEP_W'(1));
    nact      = (!pow2 && last_step) ? W8'(n) - dpair : dpair;
    send      = (W8'(droot) < nact);
    recv      = (W8'(droot) >= dpair) && (W9'(droot) < W9'(nact) + W9'(dpair));
    psend_t   = W9'(rem_me_r) + W9'(n) - W9'(dpair);
    peer_send = (psend_t >= W9'(n)) ? IDX_W'(psend_t - W9'(n)) : IDX_W'(psend_t);
    precv_t   = W9'(rem_me_r) + W9'(dpair);
    peer_recv = (precv_t >= W9'(n)) ? IDX_W'(precv_t - W9'(n)) : IDX_W'(precv_t);
    dsm       = (dslice >= W9'(n)) ? RANK_W'(dslice - W9'(n)) : RANK_W'(dslice);
  end

  // slice walk: next index steps down by the slice distance modulo n
  logic [W8-1:0]     idx_t;
  logic [IDX_W-1:0]  idx_nxt, mul_idx;
  logic [PROD_W-1:0] prod_nxt;
  always_comb begin
    idx_t    = W8'(idx_r) + W8'(n) - W8'(dsm_r);
    idx_nxt  = (idx_t >= W8'(n)) ? IDX_W'(idx_t - W8'(n)) : IDX_W'(idx_t);
    mul_idx  = cmd.prep ? idx_r : idx_nxt;
    prod_nxt = PROD_W'(mul_idx) * PROD_W'(slice_size_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_r     <= in_step;
      rep_n_r    <= REPN_W'(in_repeat_req) * REPN_W'(rank_count_r);
      dvd_me_r   <= my_index_r;
      dvd_root_r <= root_index_r;
      rem_me_r   <= '0;
      rem_root_r <= '0;
    end
    if (cmd.mod_step) begin
      rem_me_r   <= me_rem_nxt;
      rem_root_r <= root_rem_nxt;
      dvd_me_r   <= dvd_me_r << 1;
      dvd_root_r <= dvd_root_r << 1;
    end
    if (cmd.mul_lo) begin
      rbo_r <= OFF_W'(pp);
    end
    if (cmd.mul_hi) begin
      rbo_r <= rbo_r + (OFF_W'(pp) << HALF_W);
    end
    if (cmd.plan) begin
      base_r <= rbo_r + OFF_W'(scratch_base_r);
      peer_r <= send ? peer_send : peer_recv;
      idx_r  <= send ? peer_send : rem_me_r;
      dsm_r  <= dsm;
      nsl_r  <= nsl;
      if (!n_ok || !step_ok || !(send || recv)) begin
        role_r <= ROLE_IDLE;
        left_r <= CNT_W'(1);
      end else begin
        role_r <= send ? ROLE_SEND : ROLE_RECV;
        left_r <= nsl;
      end
    end
    if (cmd.prep) begin
      prod_r <= prod_nxt;
    end
    if (cmd.emit) begin
      left_r <= left_r - CNT_W'(1);
      idx_r  <= idx_nxt;
      prod_r <= prod_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (role_r == ROLE_IDLE) begin
        out_role        <= ROLE_IDLE;
        out_peer_index  <= '0;
        out_slice_index <= '0;
        out_byte_offset <= '0;
        out_slice_count <= '0;
        out_last        <= 1'b1;
      end else begin
        out_role        <= role_r;
        out_peer_index  <= peer_r;
        out_slice_index <= idx_r;
        out_byte_offset <= base_r + OFF_W'(prod_r);
        out_slice_count <= nsl_r;
        out_last        <= (left_r == CNT_W'(1));
      end
    end
  end

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.last_slice = (left_r == CNT_W'(1));

endmodule

// ----- rtl/core/scatter_halving_step_schedule.sv -----
// top level of the halving scatter step schedule
// One transaction on in_ch asks for this rank's plan in one step of a rooted
// scatter by distance halving. The block answers with one transaction per slice
// moved (role send or receive, peer, slice index, scratch byte offset), the last
// flagged by last, or with one idle transaction (all zero, last high) when this
// rank has nothing to do, the step is ceil(log2(rank_count)) or more, or rank_count
// lies outside 2..64. Items are handled one at a time: after acceptance the
// block runs the bit-serial unit that reduces my_index and root_index modulo
// rank_count (the repeat offset multiply is done in two halves in the same
// window), then a plan state picks the role and a prepare state forms the
// first slice product; then it emits one result per cycle while out_ch is not
// stalled. in_ch ready stays low from acceptance until the last result of the
// item is emitted, so out_ch stalls also delay the next item. At most 32
// results come from one item. The result register lets the final result wait
// on out_ch while the next item is taken.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), indices:
// 0 rank_count, 1 my_index, 2 root_index, 3 slice_size, 4 scratch_base; other
// indices are ignored. Write it only while no transaction is in flight.
module scatter_halving_step_schedule import shss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  shss_in_if.sink               in_ch,
  shss_out_if.source            out_ch
);

  shss_cmd_t cmd;
  shss_sts_t sts;
  role_t     out_role;

  // controller: accept, modulo window, plan, prepare, emit
  shss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath with config registers and the result register
  shss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .in_step         (in_ch.step),
    .in_repeat_req   (in_ch.repeat_req),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_role        (out_role),
    .out_peer_index  (out_ch.peer_index),
    .out_slice_index (out_ch.slice_index),
    .out_byte_offset (out_ch.byte_offset),
    .out_slice_count (out_ch.slice_count),
    .out_last        (out_ch.last)
  );

  assign out_ch.role = out_role;

  // a new request is never taken in the cycle right after one was accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted back to back");

  // idle results are single, flagged last, with zero slice count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.role == ROLE_IDLE) |-> out_ch.last && (out_ch.slice_count == '0))
    else $error("malformed idle result");

  // transfer results report a slice count within the result limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.role != ROLE_IDLE)
      |-> (out_ch.slice_count != '0) && (out_ch.slice_count <= CNT_W'(RESULT_LIMIT)))
    else $error("slice count out of range");

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the halving scatter step schedule block
`timescale 1ns / 100ps

module tb;
  import shss_pkg::*;

  localparam int RAND_ITEMS = 190;
  localparam int TAIL_ITEMS = 25;
  localparam int DIR_ROWS   = 23;

  // one result transaction as the out channel carries it
  typedef struct {
    role_t             role;
    logic [IDX_W-1:0]  peer_index;
    logic [IDX_W-1:0]  slice_index;
    logic [OFF_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  slice_count;
    logic              last;
  } plan_beat_t;

  // directed row: optional register set, one step request, optional typed answer
  typedef struct {
    logic               new_cfg;
    logic [RANK_W-1:0]  rank_count;
    logic [IDX_W-1:0]   my_index;
    logic [IDX_W-1:0]   root_index;
    logic [SLICE_W-1:0] slice_size;
    logic [BASE_W-1:0]  scratch_base;
    logic [STEP_W-1:0]  step;
    logic [REP_W-1:0]   repeat_req;
    logic               typed;
    plan_beat_t         answer;
  } dir_row_t;

  localparam plan_beat_t IDLE_BEAT = '{ROLE_IDLE, '0, '0, '0, '0, 1'b1};
  localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
  localparam logic [BASE_W-1:0]  BASE_MAX  = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  shss_in_if  in_ch ();
  shss_out_if out_ch ();

  scatter_halving_step_schedule dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // shadow copy of the register file, updated as the writes go out
  logic [RANK_W-1:0]  sh_rank_count;
  logic [IDX_W-1:0]   sh_my_index;
  logic [IDX_W-1:0]   sh_root_index;
  logic [SLICE_W-1:0] sh_slice_size;
  logic [BASE_W-1:0]  sh_scratch_base;

  // expected transfer plan results, oldest first
  plan_beat_t plan_q [$];
  dir_row_t   dir_tab [DIR_ROWS];

  int  idle_pct;     // chance of starting an idle burst: per request on the in side, per cycle on the out side
  logic quiet_tail;  // end of the run: no idling at all
  int  bad_cnt;
  int  items_sent;
  int  results_seen;
  int  send_seen;
  int  recv_seen;
  int  idle_seen;
  int  cfg_sets;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous limit: every item at 32 results, each stalled by the longest burst, is well under this
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ceil(log2(n)), capped at 16
  function automatic int unsigned steps_of(int unsigned n);
    int unsigned s;
    s = 0;
    while (s < 16 && (1 << s) < n) s++;
    return s;
  endfunction

  // append one expected result behind the ones already queued
  function automatic void queue_beat(input plan_beat_t b);
    plan_q.insert(plan_q.size(), b);
  endfunction

  // work out this rank's plan for one step and queue the results it must produce
  function automatic void predict_plan(input logic [STEP_W-1:0] step,
                                       input logic [REP_W-1:0] rep);
    int unsigned n, nsteps, me, root, droot, dpair, dslice, nslices, nact, peer, idx;
    role_t role;
    logic [OFF_W-1:0] rep_off;
    plan_beat_t b;
    n = sh_rank_count;
    // rank count outside 2..64 gives an idle step
    if (n < 2 || n > MAX_RANKS) begin
      queue_beat(IDLE_BEAT);
      return;
    end
    rep_off = 64'(rep) * 64'(n) * 64'(sh_slice_size);
    nsteps = steps_of(n);
    if (step >= nsteps) begin
      queue_beat(IDLE_BEAT);
      return;
    end
    // indexes beyond the rank count wrap
    me     = sh_my_index % n;
    root   = sh_root_index % n;
    droot  = (root + n - me) % n;
    dpair  = 1 << step;
    dslice = 1 << (step + 1);
    nslices = (n - 1 + dpair) / dslice;
    // last step is shortened when the rank count is not a power of two
    if ((n & (n - 1)) != 0 && step == nsteps - 1) nact = n - dpair;
    else nact = dpair;
    if (droot < nact) begin
      role = ROLE_SEND;
      peer = (me + n - (dpair % n)) % n;
      idx  = peer;
    end else if (droot >= dpair && droot < nact + dpair) begin
      role = ROLE_RECV;
      peer = (me + dpair) % n;
      idx  = me;
    end else begin
      queue_beat(IDLE_BEAT);
      return;
    end
    if (nslices > RESULT_LIMIT) nslices = RESULT_LIMIT;
    for (int unsigned i = 0; i < nslices; i++) begin
      b.role        = role;
      b.peer_index  = peer[IDX_W-1:0];
      b.slice_index = idx[IDX_W-1:0];
      b.byte_offset = rep_off + 64'(sh_scratch_base) + 64'(idx) * 64'(sh_slice_size);
      b.slice_count = nslices[CNT_W-1:0];
      b.last        = (i + 1 == nslices);
      queue_beat(b);
      // slices step down by twice the pair distance, modulo the rank count
      idx = (idx + n - (dslice % n)) % n;
    end
  endfunction

  // stop offering requests and let every queued result come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
  endtask

  // write all five registers, sometimes followed by a write to an unmapped index
  task automatic write_regs(input logic [RANK_W-1:0] rc, input logic [IDX_W-1:0] me,
                            input logic [IDX_W-1:0] root, input logic [SLICE_W-1:0] ssz,
                            input logic [BASE_W-1:0] base);
    cfg_idx_t order [5] = '{CFG_RANK_COUNT, CFG_MY_INDEX, CFG_ROOT_INDEX,
                            CFG_SLICE_SIZE, CFG_SCRATCH_BASE};
    logic [CFG_DATA_W-1:0] vals [5];
    vals[0] = CFG_DATA_W'(rc);
    vals[1] = CFG_DATA_W'(me);
    vals[2] = CFG_DATA_W'(root);
    vals[3] = CFG_DATA_W'(ssz);
    vals[4] = CFG_DATA_W'(base);
    for (int r = 0; r < 5; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[r];
      cfg_wdata <= vals[r];
      @(posedge clk);
    end
    if ($urandom_range(0, 3) == 0) begin
      // indexes past the last register must be ignored
      cfg_index <= CFG_SCRATCH_BASE + 3'($urandom_range(1, 3));
      cfg_wdata <= CFG_DATA_W'({$urandom, $urandom});
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sh_rank_count   = rc;
    sh_my_index     = me;
    sh_root_index   = root;
    sh_slice_size   = ssz;
    sh_scratch_base = base;
    cfg_sets++;
  endtask

  // offer one step request and hold it until the block takes the transaction
  task automatic send_item(input logic [STEP_W-1:0] step, input logic [REP_W-1:0] rep);
    if (!quiet_tail && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.step       <= step;
    in_ch.repeat_req <= rep;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // result side: random stall bursts, none in the tail
  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!quiet_tail && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    plan_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.role == ROLE_SEND) send_seen++;
      else if (out_ch.role == ROLE_RECV) recv_seen++;
      else idle_seen++;
      if (plan_q.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("%0t: result with nothing expected: role %0d peer %0d slice %0d off %h",
                   $realtime, out_ch.role, out_ch.peer_index, out_ch.slice_index,
                   out_ch.byte_offset);
      end else begin
        want = plan_q.pop_front();
        if (out_ch.role !== want.role || out_ch.peer_index !== want.peer_index ||
            out_ch.slice_index !== want.slice_index ||
            out_ch.byte_offset !== want.byte_offset ||
            out_ch.slice_count !== want.slice_count || out_ch.last !== want.last) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("%0t: mismatch (rank_count %0d my %0d root %0d)", $realtime,
                     sh_rank_count, sh_my_index, sh_root_index);
            $display("  expected role %0d peer %0d slice %0d off %h count %0d last %0d",
                     want.role, want.peer_index, want.slice_index, want.byte_offset,
                     want.slice_count, want.last);
            $display("  actual   role %0d peer %0d slice %0d off %h count %0d last %0d",
                     out_ch.role, out_ch.peer_index, out_ch.slice_index,
                     out_ch.byte_offset, out_ch.slice_count, out_ch.last);
          end
        end
      end
    end
  end

  // stimulus: directed table, then random register settings with bursts of steps
  initial begin
    int rand_items;
    int burst;
    int unsigned nsteps;
    logic [RANK_W-1:0]  rc;
    logic [SLICE_W-1:0] ssz;
    logic [BASE_W-1:0]  base;
    logic [STEP_W-1:0]  step;
    logic [63:0]        wide;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_RANK_COUNT;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.step       = '0;
    in_ch.repeat_req = '0;
    out_ch.ready     = 1'b0;
    stall_left       = 0;
    quiet_tail       = 1'b0;
    idle_pct         = 20;
    bad_cnt          = 0;
    items_sent       = 0;
    results_seen     = 0;
    send_seen        = 0;
    recv_seen        = 0;
    idle_seen        = 0;
    cfg_sets         = 0;
    rand_items       = 0;
    // register values after reset
    sh_rank_count    = 7'd2;
    sh_my_index      = '0;
    sh_root_index    = '0;
    sh_slice_size    = '0;
    sh_scratch_base  = '0;

    dir_tab = '{
      // reset values: rank 0 is the root of two ranks and sends slice 1 to rank 1
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd0, 16'h0000, 1'b1,
        '{ROLE_SEND, 6'd1, 6'd1, 64'd0, 6'd1, 1'b1}},
      // steps past the step count
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd1, 16'hFFFF, 1'b1, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd7, 16'h5A5A, 1'b1, IDLE_BEAT},
      // rank count out of range
      '{1'b1, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd0, 16'h0000, 1'b1, IDLE_BEAT},
      '{1'b1, 7'd1, 6'd63, 6'd63, SLICE_MAX, BASE_MAX, 3'd0, 16'hFFFF, 1'b1, IDLE_BEAT},
      '{1'b1, 7'd65, 6'd1, 6'd0, 40'd5, 48'd9, 3'd2, 16'h0001, 1'b1, IDLE_BEAT},
      '{1'b1, 7'd127, 6'd0, 6'd0, 40'd1, 48'd0, 3'd7, 16'h8000, 1'b1, IDLE_BEAT},
      // largest group, largest sizes
      '{1'b1, 7'd64, 6'd0, 6'd0, SLICE_MAX, BASE_MAX, 3'd0, 16'hFFFF, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd5, 16'h0001, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd6, 16'hFFFF, 1'b1, IDLE_BEAT},
      '{1'b1, 7'd64, 6'd63, 6'd0, SLICE_MAX, BASE_MAX, 3'd0, 16'hFFFF, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd5, 16'h8000, 1'b0, IDLE_BEAT},
      // five ranks: shortened last step
      '{1'b1, 7'd5, 6'd2, 6'd4, 40'h10, 48'h1000, 3'd0, 16'd3, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd1, 16'd3, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd2, 16'd3, 1'b0, IDLE_BEAT},
      // indexes beyond the rank count wrap
      '{1'b1, 7'd3, 6'd63, 6'd62, 40'h123, 48'hABC, 3'd0, 16'd7, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd1, 16'd7, 1'b0, IDLE_BEAT},
      // rank idle in the first step, receiving later
      '{1'b1, 7'd7, 6'd6, 6'd3, 40'd1, 48'd0, 3'd0, 16'd0, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd1, 16'd0, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd2, 16'd0, 1'b0, IDLE_BEAT},
      // 33 ranks: last step has a single active pair
      '{1'b1, 7'd33, 6'd40, 6'd17, 40'hABCDE, 48'h8000_0000_0000, 3'd5, 16'h00FF, 1'b0,
        IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd0, 16'hFFFF, 1'b0, IDLE_BEAT},
      '{1'b0, 7'd0, 6'd0, 6'd0, 40'd0, 48'd0, 3'd4, 16'h1234, 1'b0, IDLE_BEAT}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].new_cfg) begin
        wait_drained();
        write_regs(dir_tab[r].rank_count, dir_tab[r].my_index, dir_tab[r].root_index,
                   dir_tab[r].slice_size, dir_tab[r].scratch_base);
      end
      send_item(dir_tab[r].step, dir_tab[r].repeat_req);
      if (dir_tab[r].typed) queue_beat(dir_tab[r].answer);
      else predict_plan(dir_tab[r].step, dir_tab[r].repeat_req);
    end

    // random register settings, each followed by a burst of step requests
    while (rand_items < RAND_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       rc = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 1))
                                                  : 7'($urandom_range(65, 127));
        1:       rc = 7'd64;
        2:       rc = 7'd2;
        default: rc = 7'($urandom_range(3, 63));
      endcase
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       ssz = SLICE_MAX;
        1:       ssz = wide[SLICE_W-1:0];
        default: ssz = 40'($urandom_range(0, 4096));
      endcase
      wide = {$urandom, $urandom};
      base = ($urandom_range(0, 4) == 0) ? '0 : wide[BASE_W-1:0];
      write_regs(rc, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), ssz, base);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      nsteps = steps_of(rc);
      if (rc < 2 || rc > MAX_RANKS) nsteps = 0;
      burst = $urandom_range(8, 16);
      for (int j = 0; j < burst && rand_items < RAND_ITEMS; j++) begin
        quiet_tail = (RAND_ITEMS - rand_items) <= TAIL_ITEMS;
        // mostly steps the group actually runs, some past the end
        if (nsteps != 0 && $urandom_range(0, 99) < 85)
          step = 3'($urandom_range(0, nsteps - 1));
        else
          step = 3'($urandom_range(0, 7));
        wide[REP_W-1:0] = 16'($urandom_range(0, 65535));
        send_item(step, wide[REP_W-1:0]);
        predict_plan(step, wide[REP_W-1:0]);
        rand_items++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("run covered %0d step requests over %0d register settings", items_sent,
             cfg_sets + 1);
    $display("%0d results checked: %0d send, %0d receive, %0d idle; %0d mismatches",
             results_seen, send_seen, recv_seen, idle_seen, bad_cnt);
    if (bad_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
